// ===== hdl/array_list_engine_macros.svh =====
// Assertion macros shared by the array list engine RTL.
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ALE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ALE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/alist_pkg.sv =====
// Package with widths, command and status codes and cell types of the array list engine.
`default_nettype none
package alist_pkg;

  localparam int DEPTH  = 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int OP_W   = 4;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 32;
  localparam int AMT_W  = 8;
  localparam int ST_W   = 3;
  localparam int FIDX_W = 3;
  localparam int BITS_W = $clog2(AMT_W);
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 4'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 4'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 4'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 4'd5;
  localparam logic [OP_W-1:0] OP_SEARCH    = 4'd6;
  localparam logic [OP_W-1:0] OP_ROTATE    = 4'd7;
  localparam logic [OP_W-1:0] OP_READ      = 4'd8;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  typedef logic [1:0] cell_op_t;

  localparam cell_op_t CELL_HOLD  = 2'd0;
  localparam cell_op_t CELL_LOAD  = 2'd1;
  localparam cell_op_t CELL_LEFT  = 2'd2;
  localparam cell_op_t CELL_RIGHT = 2'd3;

  // Per-cell control: what the cell does this cycle, and the word it loads or compares.
  typedef struct packed {
    cell_op_t          op;
    logic [VAL_W-1:0]  word;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/alist_if.sv =====
// Handshake channels for commands into and results out of the array list engine.
`default_nettype none
interface alist_in_if;
  import alist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [VAL_W-1:0]  value;
  logic [AMT_W-1:0]         rotate_amount;

  modport source (output valid, operation, position, value, rotate_amount, input ready);
  modport sink (input valid, operation, position, value, rotate_amount, output ready);
endinterface

interface alist_out_if;
  import alist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic [FIDX_W-1:0]        found_index;
  logic signed [VAL_W-1:0]  data_out;
  logic [CNT_W-1:0]         count;

  modport source (output valid, status, found_index, data_out, count, input ready);
  modport sink (input valid, status, found_index, data_out, count, output ready);
endinterface
`default_nettype wire

// ===== hdl/array_list_engine.sv =====
// Array list engine top level: command decode, cell chain, rotate sequencer, result register.
// Inserts, deletes, searches and reads deliver their result in the cycle after acceptance.
// A rotate first reduces the amount modulo the count to k (k < count) in the bit-serial
// remainder unit, then performs k single-step rotations of the cell chain, one per cycle.
// Commands are handled one at a time; a new command is taken once the previous one is done.
// Reset (synchronous, rst_n low) clears the count, the sequencer and the result valid flag.
`default_nettype none
`include "array_list_engine_macros.svh"
module array_list_engine (
  input  logic         clk,
  input  logic         rst_n,
  alist_in_if.sink     in_ch,
  alist_out_if.source  out_ch
);
  import alist_pkg::*;

  // Sequencer states. Idle handles every command but rotate in the cycle it is accepted.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_ROT  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  step_r, step_nxt;

  // Result register that separates the result channel from the engine.
  logic              ov_r, ov_nxt;
  logic [ST_W-1:0]   ost_r, ost_nxt;
  logic [FIDX_W-1:0] ofi_r, ofi_nxt;
  logic [VAL_W-1:0]  odat_r, odat_nxt;
  logic [CNT_W-1:0]  ocnt_r, ocnt_nxt;

  logic              out_free;
  logic              in_acc;

  // Command decode.
  logic              is_ins, is_del;
  logic              do_ins, do_del, go_rot;
  logic [CMP_W-1:0]  pos_w, cnt_w, tgt;
  logic [ST_W-1:0]   status;
  logic [FIDX_W-1:0] found;
  logic [VAL_W-1:0]  rd_data;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;

  // Cell chain.
  cell_ctl_t         ctl [DEPTH];
  logic [VAL_W-1:0]  cell_q [DEPTH];
  logic              cell_match [DEPTH];
  logic [VAL_W-1:0]  wrap_d;

  logic              mod_done;
  logic [CNT_W-1:0]  mod_rem;

  assign out_free    = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign pos_w = CMP_W'(in_ch.position);
  assign cnt_w = CMP_W'(cnt_r);

  // The last valid entry feeds the head cell during a rotation step.
  assign wrap_d = cell_q[IDX_W'(cnt_w - 1'b1)];

  // First valid matching cell, lowest index wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i] && (CMP_W'(i) < cnt_w)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign rd_data = cell_q[IDX_W'(pos_w)];

  always_comb begin
    is_ins = 1'b0;
    is_del = 1'b0;
    do_ins = 1'b0;
    do_del = 1'b0;
    go_rot = 1'b0;
    tgt    = '0;
    status = ST_OK;
    found  = '0;
    odat_nxt = '0;
    case (in_ch.operation)
      OP_INS_FRONT: begin
        is_ins = 1'b1;
      end
      OP_INS_BACK: begin
        is_ins = 1'b1;
        tgt    = cnt_w;
      end
      OP_INS_AT: begin
        is_ins = 1'b1;
        tgt    = pos_w;
      end
      OP_DEL_FRONT: begin
        is_del = 1'b1;
      end
      OP_DEL_BACK: begin
        // An empty list is caught by the empty check before the position is used.
        is_del = 1'b1;
        tgt    = cnt_w - 1'b1;
      end
      OP_DEL_AT: begin
        is_del = 1'b1;
        tgt    = pos_w;
      end
      OP_SEARCH: begin
        if (hit) begin
          found = FIDX_W'(hit_idx);
        end else begin
          status = ST_NOTFOUND;
        end
      end
      OP_ROTATE: begin
        if (cnt_r == '0) begin
          status = ST_EMPTY;
        end else begin
          go_rot = 1'b1;
        end
      end
      OP_READ: begin
        if (cnt_r == '0) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_BADPOS;
        end else begin
          odat_nxt = rd_data;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    if (is_ins) begin
      if (cnt_r == CNT_W'(DEPTH)) begin
        status = ST_FULL;
      end else if (tgt > cnt_w) begin
        status = ST_BADPOS;
      end else begin
        do_ins = 1'b1;
      end
    end
    if (is_del) begin
      if (cnt_r == '0) begin
        status = ST_EMPTY;
      end else if (tgt >= cnt_w) begin
        status = ST_BADPOS;
      end else begin
        do_del = 1'b1;
      end
    end
  end

  // Cell controls. An insert opens a gap at the target by moving the tail up one cell, a delete
  // closes it by moving the tail down, and a rotation step moves every valid entry up by one
  // with the last entry wrapping into the head cell.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] left_d;
    logic [VAL_W-1:0] right_d;

    always_comb begin
      ctl[g].word = in_ch.value;
      ctl[g].op   = CELL_HOLD;
      if (in_acc && do_ins) begin
        if (CMP_W'(g) == tgt) begin
          ctl[g].op = CELL_LOAD;
        end else if (CMP_W'(g) > tgt) begin
          ctl[g].op = CELL_LEFT;
        end
      end else if (in_acc && do_del) begin
        if (CMP_W'(g) >= tgt) begin
          ctl[g].op = CELL_RIGHT;
        end
      end else if ((state_r == S_ROT) && (step_r != '0) && (CMP_W'(g) < cnt_w)) begin
        ctl[g].op = CELL_LEFT;
      end
    end

    if (g == 0) begin : g_head
      assign left_d = wrap_d;
    end else begin : g_body
      assign left_d = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_d = cell_q[g];
    end else begin : g_inner
      assign right_d = cell_q[g+1];
    end

    alist_cell u_cell (
      .clk     (clk),
      .ctl     (ctl[g]),
      .left_d  (left_d),
      .right_d (right_d),
      .q       (cell_q[g]),
      .match   (cell_match[g])
    );
  end

  alist_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc && go_rot),
    .amount  (in_ch.rotate_amount),
    .divisor (cnt_r),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // Sequencer, count and result register.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    ov_nxt    = ov_r && !out_ch.ready;
    ost_nxt   = ost_r;
    ofi_nxt   = ofi_r;
    ocnt_nxt  = ocnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (do_ins) begin
            cnt_nxt = cnt_r + 1'b1;
          end else if (do_del) begin
            cnt_nxt = cnt_r - 1'b1;
          end
          if (go_rot) begin
            state_nxt = S_MOD;
          end else begin
            ov_nxt   = 1'b1;
            ost_nxt  = status;
            ofi_nxt  = found;
            ocnt_nxt = cnt_nxt;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          step_nxt  = mod_rem;
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        if (step_r != '0) begin
          step_nxt = step_r - 1'b1;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_OK;
          ofi_nxt   = '0;
          ocnt_nxt  = cnt_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    step_r <= step_nxt;
    ost_r  <= ost_nxt;
    ofi_r  <= ofi_nxt;
    ocnt_r <= ocnt_nxt;
    // The read data only changes when a new result is loaded; rotate results carry zero.
    if (in_acc && !go_rot) begin
      odat_r <= odat_nxt;
    end else if ((state_r == S_ROT) && (step_r == '0) && out_free) begin
      odat_r <= '0;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.status      = ost_r;
  assign out_ch.found_index = ofi_r;
  assign out_ch.data_out    = odat_r;
  assign out_ch.count       = ocnt_r;

  // A busy sequencer never changes the entry count.
  `ALE_ASSERT_NEXT(a_busy_count_held, state_r != S_IDLE, cnt_r == $past(cnt_r), "count moved during rotate")
  // A rotate accepted on a non-empty list starts the remainder unit.
  `ALE_ASSERT_NEXT(a_rot_starts_mod, in_acc && go_rot, state_r == S_MOD, "rotate did not start")
  // The remaining rotation steps always stay below the entry count.
  `ALE_ASSERT_NOW(a_step_below_count, state_r == S_ROT, step_r < cnt_r, "rotate steps exceed count")
endmodule
`default_nettype wire

// ===== hdl/alist_cell.sv =====
// One storage cell of the list chain: holds, loads, or takes a neighbor's entry.
`default_nettype none
module alist_cell (
  input  logic                          clk,
  input  alist_pkg::cell_ctl_t          ctl,
  input  logic [alist_pkg::VAL_W-1:0]   left_d,
  input  logic [alist_pkg::VAL_W-1:0]   right_d,
  output logic [alist_pkg::VAL_W-1:0]   q,
  output logic                          match
);
  import alist_pkg::*;

  logic [VAL_W-1:0] data_r;

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_LOAD:  data_r <= ctl.word;
      CELL_LEFT:  data_r <= left_d;
      CELL_RIGHT: data_r <= right_d;
      default:    data_r <= data_r;
    endcase
  end

  assign q     = data_r;
  assign match = (data_r == ctl.word);
endmodule
`default_nettype wire

// ===== hdl/alist_mod.sv =====
// Bit-serial remainder unit: amount modulo the entry count, one quotient bit per cycle.
`default_nettype none
module alist_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [alist_pkg::AMT_W-1:0]   amount,
  input  logic [alist_pkg::CNT_W-1:0]   divisor,
  output logic                          done,
  output logic [alist_pkg::CNT_W-1:0]   rem
);
  import alist_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [BITS_W-1:0] left_r, left_nxt;
  logic [AMT_W-1:0]  sh_r, sh_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    left_nxt = left_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, sh_r[AMT_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      left_nxt = BITS_W'(AMT_W - 1);
      sh_nxt   = amount;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // Restoring step: the partial remainder stays below twice the divisor.
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = CNT_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = CNT_W'(trial);
      end
      sh_nxt   = {sh_r[AMT_W-2:0], 1'b0};
      left_nxt = left_r - 1'b1;
      if (left_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    left_r <= left_nxt;
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

// ===== sim/array_list_engine_test.sv =====
// Self-checking testbench for the array list engine: directed and random commands, scoreboard.
`default_nettype none
module array_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import alist_pkg::*;

  // Command codes above OP_READ carry no meaning; the block must leave the list alone.
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_READ + 4'd1;
  localparam logic [OP_W-1:0] OP_LAST_CODE    = '1;

  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS   = 50;

  // One result item as the block should present it.
  typedef struct {
    logic [ST_W-1:0]         status;
    logic [FIDX_W-1:0]       found_index;
    logic signed [VAL_W-1:0] data_out;
    logic [CNT_W-1:0]        count;
  } list_result_t;

  // The scoreboard keeps its own copy of the list. Every accepted command is
  // applied to that copy at once, and the result it should give is queued
  // until the block delivers its answer.
  class list_scoreboard;
    logic signed [VAL_W-1:0] entries [DEPTH];
    int                      entry_count = 0;
    list_result_t            pending [$];
    int                      results_seen = 0;
    int                      errors = 0;

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) begin
        $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
      end
      errors++;
    endtask

    function logic [ST_W-1:0] insert_at(int pos, logic signed [VAL_W-1:0] val);
      if (entry_count >= DEPTH) return ST_FULL;
      if (pos > entry_count) return ST_BADPOS;
      for (int i = entry_count; i > pos; i--) begin
        entries[i] = entries[i-1];
      end
      entries[pos] = val;
      entry_count++;
      return ST_OK;
    endfunction

    function logic [ST_W-1:0] remove_at(int pos);
      if (entry_count == 0) return ST_EMPTY;
      if (pos >= entry_count) return ST_BADPOS;
      for (int i = pos; i + 1 < entry_count; i++) begin
        entries[i] = entries[i+1];
      end
      entry_count--;
      return ST_OK;
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] val, logic [AMT_W-1:0] amt);
      list_result_t            r;
      int                      n;
      int                      k;
      bit                      hit;
      logic signed [VAL_W-1:0] spun [DEPTH];
      r.status      = ST_OK;
      r.found_index = '0;
      r.data_out    = '0;
      hit           = 1'b0;
      n             = entry_count;
      case (op)
        OP_INS_FRONT: r.status = insert_at(0, val);
        OP_INS_BACK:  r.status = insert_at(entry_count, val);
        OP_INS_AT:    r.status = insert_at(int'(pos), val);
        OP_DEL_FRONT: r.status = remove_at(0);
        OP_DEL_BACK:  r.status = (entry_count == 0) ? ST_EMPTY : remove_at(entry_count - 1);
        OP_DEL_AT:    r.status = remove_at(int'(pos));
        OP_SEARCH: begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < n; i++) begin
            if (!hit && entries[i] == val) begin
              hit           = 1'b1;
              r.status      = ST_OK;
              r.found_index = i[FIDX_W-1:0];
            end
          end
        end
        OP_ROTATE: begin
          if (n == 0) begin
            r.status = ST_EMPTY;
          end else begin
            k = int'(amt) % n;
            for (int i = 0; i < n; i++) spun[(i + k) % n] = entries[i];
            for (int i = 0; i < n; i++) entries[i] = spun[i];
          end
        end
        OP_READ: begin
          if (n == 0) r.status = ST_EMPTY;
          else if (int'(pos) >= n) r.status = ST_BADPOS;
          else r.data_out = entries[pos];
        end
        default: ;
      endcase
      r.count = entry_count[CNT_W-1:0];
      pending.push_back(r);
    endfunction

    task check_result(logic [ST_W-1:0] status, logic [FIDX_W-1:0] found_index,
                      logic signed [VAL_W-1:0] data_out, logic [CNT_W-1:0] count);
      list_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = pending.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status expected %0d got %0d", want.status, status));
        if (found_index !== want.found_index)
          report_mismatch($sformatf("found_index expected %0d got %0d",
                                    want.found_index, found_index));
        if (data_out !== want.data_out)
          report_mismatch($sformatf("data_out expected %08h got %08h", want.data_out,
                                    data_out));
        if (count !== want.count)
          report_mismatch($sformatf("count expected %0d got %0d", want.count, count));
      end
      results_seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  alist_in_if  in_ch ();
  alist_out_if out_ch ();

  array_list_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_scoreboard sb = new;

  // While this is set, neither side inserts idle cycles.
  bit steady_run = 1'b0;

  always #5ns clk = ~clk;

  // Offer one command item. Idle cycles come first, then the item is held
  // until the block takes it, and only then is it applied to the scoreboard.
  // Valid is only ever written at falling edges, once per edge.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val,
                              input logic [AMT_W-1:0] amt);
    @(negedge clk);
    while (!steady_run && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.position      <= pos;
    in_ch.value         <= val;
    in_ch.rotate_amount <= amt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_command(op, pos, val, amt);
  endtask

  // Random command shaped by the current fill level: inserts dominate on a
  // short list and deletes on a long one, so the list keeps moving between
  // empty and full. Positions mostly fall in the legal range, values often
  // repeat or copy a stored entry so that searches find something.
  task automatic random_command();
    int                      n;
    int                      r;
    int                      ins_w;
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    logic [AMT_W-1:0]        amt;
    n     = sb.entry_count;
    ins_w = 60 - 5 * n;
    r     = $urandom_range(99);
    if (r < 3) begin
      op = OP_W'($urandom_range(OP_LAST_CODE, OP_FIRST_UNUSED));
    end else if (r < 3 + ins_w) begin
      op = OP_W'(OP_INS_FRONT + $urandom_range(2));
    end else begin
      r = $urandom_range(99);
      if (r < 45) op = OP_W'(OP_DEL_FRONT + $urandom_range(2));
      else if (r < 65) op = OP_SEARCH;
      else if (r < 75) op = OP_ROTATE;
      else op = OP_READ;
    end
    if ($urandom_range(99) < 85) pos = POS_W'($urandom_range(n));
    else pos = POS_W'($urandom);
    r = $urandom_range(99);
    if (n > 0 && r < ((op == OP_SEARCH) ? 70 : 25)) val = sb.entries[$urandom_range(n - 1)];
    else if (r < 75) val = $urandom_range(8) - 4;
    else val = $urandom;
    amt = AMT_W'($urandom);
    send_command(op, pos, val, amt);
  endtask

  // Receiver: random back-pressure, plus two long hold-offs once enough
  // results have come, so the engine backs up and stalls the command side.
  initial begin
    int hold_left;
    int hold_mark;
    int holds_done;
    hold_left    = 0;
    hold_mark    = 300;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (holds_done < 2 && sb.results_seen >= hold_mark) begin
        out_ch.ready <= 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        hold_mark    += 700;
        holds_done++;
      end else begin
        out_ch.ready <= steady_run || ($urandom_range(99) >= 37);
      end
    end
  end

  // Every result item taken at a rising edge is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.status, out_ch.found_index, out_ch.data_out, out_ch.count);
    end
  end

  // Main sequence: reset, directed corner cases, random traffic, drain, verdict.
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_INS_FRONT;
    in_ch.position      = '0;
    in_ch.value         = '0;
    in_ch.rotate_amount = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Everything that can fail on an empty list.
    send_command(OP_READ,      4'd0,  32'sd0, 8'd0);
    send_command(OP_DEL_FRONT, 4'd0,  32'sd0, 8'd0);
    send_command(OP_DEL_BACK,  4'd0,  32'sd0, 8'd0);
    send_command(OP_DEL_AT,    4'd0,  32'sd0, 8'd0);
    send_command(OP_ROTATE,    4'd0,  32'sd0, 8'd5);
    send_command(OP_SEARCH,    4'd0,  32'sd0, 8'd0);
    send_command(OP_INS_AT,    4'd1,  32'sd7, 8'd0);
    // Build a short list holding both value extremes and -1.
    send_command(OP_INS_BACK,  4'd0,  32'sh7FFF_FFFF, 8'd0);
    send_command(OP_INS_FRONT, 4'd0,  32'sh8000_0000, 8'd0);
    send_command(OP_INS_AT,    4'd2,  -32'sd1, 8'd0);
    send_command(OP_INS_AT,    4'd1,  32'sd0, 8'd0);
    send_command(OP_READ,      4'd15, 32'sd0, 8'd0);
    send_command(OP_SEARCH,    4'd0,  -32'sd1, 8'd0);
    send_command(OP_SEARCH,    4'd0,  32'sd12345, 8'd0);
    // A rotation by a multiple of the count changes nothing; the widest amount wraps.
    send_command(OP_ROTATE,    4'd0,  32'sd0, 8'd8);
    send_command(OP_ROTATE,    4'd0,  32'sd0, 8'd255);
    // Fill up, then try to insert into a full list, once with a bad position too.
    for (int i = 1; i <= 4; i++) send_command(OP_INS_BACK, 4'd0, i, 8'd0);
    send_command(OP_INS_FRONT, 4'd0,  32'sd99, 8'd0);
    send_command(OP_INS_AT,    4'd15, 32'sd99, 8'd0);
    send_command(OP_READ,      4'd7,  32'sd0, 8'd0);
    send_command(OP_DEL_AT,    4'd8,  32'sd0, 8'd0);
    send_command(OP_DEL_AT,    4'd3,  32'sd0, 8'd0);
    send_command(OP_DEL_BACK,  4'd0,  32'sd0, 8'd0);
    send_command(OP_DEL_FRONT, 4'd0,  32'sd0, 8'd0);
    // Undefined command codes, with every payload bit set on one of them.
    send_command(OP_LAST_CODE,    4'd15, -32'sd1, 8'd255);
    send_command(OP_FIRST_UNUSED, 4'd0,  32'sd0,  8'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady_run = (i >= 500 && i < 700);
      random_command();
    end
    steady_run = 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/alist_pkg.sv
hdl/alist_if.sv
hdl/alist_cell.sv
hdl/alist_mod.sv
hdl/array_list_engine.sv
sim/array_list_engine_test.sv
